// File: hdl/eiep_pkg.sv
// ----------------------------------------------------------------------------
// eiep_pkg
// Types and constants shared by the external interrupt edge-pending unit:
// request/response payload structs, operation codes and register indexes.
// ----------------------------------------------------------------------------
package eiep_pkg;

	// Width of every per-line bit vector on the bus side
	localparam int unsigned FIELD_W = 23;
	localparam int unsigned OP_W    = 3;
	localparam int unsigned LINE_W  = 5;

	// APB-side widths
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned APB_ADDR_W = 4;

	// Operation codes; codes 5..7 are no-ops
	typedef enum logic [OP_W-1:0] {
		OP_EVENT    = 3'd0,
		OP_WR_SOFT  = 3'd1,
		OP_WR_CLEAR = 3'd2,
		OP_RD_PEND  = 3'd3,
		OP_RD_SOFT  = 3'd4
	} op_t;

	// Configuration register indexes (word address); index 3 is unmapped
	typedef enum logic [1:0] {
		REG_MASK_ENABLE    = 2'd0,
		REG_RISING_SELECT  = 2'd1,
		REG_FALLING_SELECT = 2'd2
	} reg_idx_t;

	// Request payload
	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [LINE_W-1:0]  line;
		logic               level;
		logic [FIELD_W-1:0] write_data;
	} req_t;

	// Response payload
	typedef struct packed {
		logic [FIELD_W-1:0] read_data;
		logic [FIELD_W-1:0] irq_lines;
	} rsp_t;

endpackage

// File: hdl/external_interrupt_edge_pending_unit.sv
// ----------------------------------------------------------------------------
// external_interrupt_edge_pending_unit
// External interrupt line controller with per-line edge-pending bits.
//
// Each request is either a line event (line index plus new level), a software
// trigger write, a pending-clear write, or a read of the pending or software
// trigger register; every request yields exactly one response carrying the
// read data (zero for non-reads) and the interrupt vector, which equals the
// pending bits after that request. The unit takes one request per cycle while
// the response side keeps up: a request is registered in the input stage, is
// resolved against the pending/trigger state by single-level bitwise logic,
// and lands in the response register. mask_enable, rising_select and
// falling_select are written over APB at byte addresses 0x0, 0x4 and 0x8.
// Lines at or above LINES never pend and read back as zero.
// ----------------------------------------------------------------------------
module external_interrupt_edge_pending_unit #(
	parameter int unsigned LINES = 23
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// request channel
	input  logic                                 req_valid,
	output logic                                 req_ready,
	input  eiep_pkg::req_t                       req_data,
	// response channel
	output logic                                 rsp_valid,
	input  logic                                 rsp_ready,
	output eiep_pkg::rsp_t                       rsp_data,
	// configuration port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [eiep_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [eiep_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [eiep_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                 pready
);

	import eiep_pkg::*;

	// Bits of lines that exist
	localparam logic [FIELD_W-1:0] LINE_MASK = (LINES >= FIELD_W) ? {FIELD_W{1'b1}} :
		FIELD_W'((64'd1 << LINES) - 64'd1);
	localparam logic [LINE_W:0] LINES_CMP = (LINE_W+1)'(LINES);

	// Configuration registers
	logic [FIELD_W-1:0] mask_enable_q;
	logic [FIELD_W-1:0] rising_select_q;
	logic [FIELD_W-1:0] falling_select_q;

	// Interrupt state
	logic [FIELD_W-1:0] pending_q;
	logic [FIELD_W-1:0] soft_trig_q;

	// Input stage
	logic               req_vld_s1;
	req_t               req_s1;

	// Response register
	logic               rsp_vld_q;
	rsp_t               rsp_q;

	logic               rsp_load;
	logic               advance;
	logic               cfg_wr;
	reg_idx_t           cfg_idx;

	logic [FIELD_W-1:0] wdata_m;
	logic [FIELD_W-1:0] line_bit;
	logic [FIELD_W-1:0] edge_sel;
	logic [FIELD_W-1:0] soft_nxt;
	logic [FIELD_W-1:0] pending_nxt;
	logic [FIELD_W-1:0] soft_trig_nxt;
	logic [FIELD_W-1:0] rdata;

	// APB access
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_enable_q    <= '0;
			rising_select_q  <= '0;
			falling_select_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_MASK_ENABLE:    mask_enable_q    <= pwdata[FIELD_W-1:0] & LINE_MASK;
				REG_RISING_SELECT:  rising_select_q  <= pwdata[FIELD_W-1:0] & LINE_MASK;
				REG_FALLING_SELECT: falling_select_q <= pwdata[FIELD_W-1:0] & LINE_MASK;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_MASK_ENABLE:    prdata = APB_DATA_W'(mask_enable_q);
			REG_RISING_SELECT:  prdata = APB_DATA_W'(rising_select_q);
			REG_FALLING_SELECT: prdata = APB_DATA_W'(falling_select_q);
			default:            prdata = '0;
		endcase
	end

	// Handshake: response register frees when empty or being taken
	assign rsp_load  = ~rsp_vld_q | rsp_ready;
	assign advance   = req_vld_s1 & rsp_load;
	assign req_ready = ~req_vld_s1 | rsp_load;
	assign rsp_valid = rsp_vld_q;
	assign rsp_data  = rsp_q;

	// Input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_vld_s1 <= 1'b0;
		end else if (req_ready) begin
			req_vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req_data;
		end
	end

	// Request resolution
	always_comb begin
		wdata_m       = req_s1.write_data & LINE_MASK;
		line_bit      = ({1'b0, req_s1.line} < LINES_CMP) ?
			((FIELD_W'(1) << req_s1.line) & LINE_MASK) : '0;
		edge_sel      = req_s1.level ? rising_select_q : falling_select_q;
		soft_nxt      = wdata_m & mask_enable_q;
		pending_nxt   = pending_q;
		soft_trig_nxt = soft_trig_q;
		rdata         = '0;
		case (op_t'(req_s1.op))
			OP_EVENT: begin
				pending_nxt = pending_q | (line_bit & mask_enable_q & edge_sel);
			end
			OP_WR_SOFT: begin
				soft_trig_nxt = soft_nxt;
				pending_nxt   = pending_q | (soft_nxt & ~soft_trig_q);
			end
			OP_WR_CLEAR: begin
				pending_nxt = pending_q & ~wdata_m;
			end
			OP_RD_PEND: begin
				rdata = pending_q;
			end
			OP_RD_SOFT: begin
				rdata = soft_trig_q;
			end
			default: ;
		endcase
	end

	// State and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= '0;
			soft_trig_q <= '0;
			rsp_vld_q   <= 1'b0;
		end else begin
			if (advance) begin
				pending_q   <= pending_nxt;
				soft_trig_q <= soft_trig_nxt;
			end
			if (rsp_load) begin
				rsp_vld_q <= req_vld_s1;
			end
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q.read_data <= rdata;
			rsp_q.irq_lines <= pending_nxt;
		end
	end

endmodule
